/* sv/dsa_pkg.sv */
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared types and codes of the descriptor slot allocator.
// ----------------------------------------------------------------------------
package dsa_pkg;

  localparam int unsigned IDX_W   = 10;
  localparam int unsigned CAP_W   = 11;
  localparam int unsigned STRD_W  = 16;
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned CNT_W   = 12;
  localparam int unsigned PROD_W  = IDX_W + STRD_W;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic [IDX_W-1:0]  slot_idx_t;
  typedef logic [CNT_W-1:0]  free_cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Operation codes of the input word
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_HEAP_FULL = 2'd1,
    ST_BAD_HANDLE = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY       = 3'd0,
    CFG_STRIDE_BYTES   = 3'd1,
    CFG_CPU_BASE       = 3'd2,
    CFG_GPU_BASE       = 3'd3,
    CFG_SHADER_VISIBLE = 3'd4
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_CALC,
    S_ADD
  } state_t;

  // One operation in flight between decode and address calculation
  typedef struct packed {
    logic      got;       // a slot was handed out
    logic      from_ram;  // slot index comes from the free stack read port
    status_t   status;
    slot_idx_t idx;       // bump slot index when not from_ram
    free_cnt_t free_count;
  } job_t;

endpackage

/* sv/descriptor_slot_allocator_core.sv */
// ----------------------------------------------------------------------------
// descriptor_slot_allocator_core
// Slot allocator: LIFO free stack in front of a bump pointer.
// ----------------------------------------------------------------------------
// Each input word is one allocate or one free and yields exactly one result
// word. An allocate pops the most recently freed slot when the free stack
// holds any, else takes the bump pointer while it is below the capacity
// (capacity saturates at MAX_SLOTS), else reports heap full. Addresses are
// base + index * stride modulo 2^64; the GPU address is 0 unless shader
// visibility is set. A valid free pushes the index as given (no range or
// duplicate check); an invalid handle changes no state and is reported as
// a bad handle; a push onto a full stack is dropped and flagged. Timing:
// one word is in flight at a time. A pop passes through accept/decode
// with the free stack RAM read issued at the accepting edge, S_POP, the
// index-times-stride multiply in S_CALC and the 64-bit base add into the
// output register in S_ADD; a bump allocate, a failed allocate or a free
// skips S_POP. The block returns to S_IDLE, the only accepting state, when
// the result is loaded. The result sits in an output register, so the next
// word is accepted while a result waits for out_ready; a new result cannot
// be loaded until the old one is taken, which stalls the block in S_ADD.
// The free stack RAM needs no clearing pass: only entries below the stack
// depth are read. Write configuration only while no word is in flight.
// ----------------------------------------------------------------------------
module descriptor_slot_allocator_core #(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_opcode,
  input  logic [dsa_pkg::IDX_W-1:0]       in_free_index,
  input  logic                            in_handle_valid,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [dsa_pkg::IDX_W-1:0]       out_slot_index,
  output logic [dsa_pkg::ADDR_W-1:0]      out_cpu_address,
  output logic [dsa_pkg::ADDR_W-1:0]      out_gpu_address,
  output logic [dsa_pkg::CNT_W-1:0]       out_free_count,
  // configuration port
  input  logic                            cfg_we,
  input  logic [dsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dsa_pkg::ADDR_W-1:0]      cfg_wdata
);

  // Stack depth counts 0..MAX_SLOTS; RAM address covers 0..MAX_SLOTS-1
  localparam int unsigned DW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  // Width that holds both the 11-bit capacity and MAX_SLOTS
  localparam int unsigned EW = (DW > dsa_pkg::CAP_W) ? DW : dsa_pkg::CAP_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [dsa_pkg::CAP_W-1:0]  cap_r;
  logic [dsa_pkg::STRD_W-1:0] stride_r;
  dsa_pkg::addr_t             cpu_base_r;
  dsa_pkg::addr_t             gpu_base_r;
  logic                       vis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= dsa_pkg::CAP_W'(1024);
      stride_r   <= dsa_pkg::STRD_W'(32);
      cpu_base_r <= '0;
      gpu_base_r <= '0;
      vis_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsa_pkg::CFG_CAPACITY:       cap_r      <= cfg_wdata[dsa_pkg::CAP_W-1:0];
        dsa_pkg::CFG_STRIDE_BYTES:   stride_r   <= cfg_wdata[dsa_pkg::STRD_W-1:0];
        dsa_pkg::CFG_CPU_BASE:       cpu_base_r <= cfg_wdata;
        dsa_pkg::CFG_GPU_BASE:       gpu_base_r <= cfg_wdata;
        dsa_pkg::CFG_SHADER_VISIBLE: vis_r      <= cfg_wdata[0];
        default: begin
          // indexes beyond the register list are dropped
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  dsa_pkg::state_t state_r, state_nxt;
  logic            in_fire;
  logic            calc_en;
  logic            out_load;
  logic            out_valid_r;

  dsa_pkg::job_t   job_r, job_nxt;
  logic [DW-1:0]   depth_r, depth_nxt;
  logic [dsa_pkg::CAP_W-1:0] bump_r, bump_nxt;

  assign in_fire = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dsa_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = job_nxt.from_ram ? dsa_pkg::S_POP : dsa_pkg::S_CALC;
        end
      end
      dsa_pkg::S_POP:  state_nxt = dsa_pkg::S_CALC;
      dsa_pkg::S_CALC: state_nxt = dsa_pkg::S_ADD;
      dsa_pkg::S_ADD: begin
        if (out_load) begin
          state_nxt = dsa_pkg::S_IDLE;
        end
      end
      default: state_nxt = dsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    calc_en  = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      dsa_pkg::S_IDLE: in_ready = 1'b1;
      dsa_pkg::S_POP:  ;
      dsa_pkg::S_CALC: calc_en  = 1'b1;
      dsa_pkg::S_ADD:  out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dsa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Decode: pick the slot source, update depth and bump, count free slots
  // --------------------------------------------------------------------------
  logic [EW-1:0] eff_cap;
  logic [EW-1:0] bump_ext;
  logic [EW-1:0] fresh;
  logic [EW:0]   free_sum;
  logic          stack_full;
  logic          push;
  logic          pop;
  logic [DW-1:0] depth_dec;

  assign depth_dec  = depth_r - DW'(1);
  assign stack_full = (depth_r == DW'(MAX_SLOTS));

  // Saturate the capacity at the stack size
  always_comb begin
    eff_cap = EW'(cap_r);
    if (EW'(cap_r) > EW'(MAX_SLOTS)) begin
      eff_cap = EW'(MAX_SLOTS);
    end
  end

  always_comb begin
    job_nxt   = '0;
    depth_nxt = depth_r;
    bump_nxt  = bump_r;
    push      = 1'b0;
    pop       = 1'b0;
    job_nxt.status = dsa_pkg::ST_OK;
    if (dsa_pkg::opcode_t'(in_opcode) == dsa_pkg::OP_ALLOC) begin
      // stack first, then the bump pointer
      priority if (depth_r != '0) begin
        pop              = 1'b1;
        depth_nxt        = depth_dec;
        job_nxt.got      = 1'b1;
        job_nxt.from_ram = 1'b1;
      end else if (EW'(bump_r) < eff_cap) begin
        bump_nxt     = bump_r + dsa_pkg::CAP_W'(1);
        job_nxt.got  = 1'b1;
        job_nxt.idx  = bump_r[dsa_pkg::IDX_W-1:0];
      end else begin
        job_nxt.status = dsa_pkg::ST_HEAP_FULL;
      end
    end else begin
      priority if (!in_handle_valid) begin
        job_nxt.status = dsa_pkg::ST_BAD_HANDLE;
      end else if (stack_full) begin
        job_nxt.status = dsa_pkg::ST_OVERFLOW;
      end else begin
        push      = 1'b1;
        depth_nxt = depth_r + DW'(1);
      end
    end

    // free count after the operation, floored at zero on the bump side
    bump_ext = EW'(bump_nxt);
    fresh    = (bump_ext < eff_cap) ? eff_cap - bump_ext : '0;
    free_sum = (EW + 1)'(fresh) + (EW + 1)'(depth_nxt);
    job_nxt.free_count = free_sum[dsa_pkg::CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      bump_r  <= '0;
    end else if (in_fire) begin
      depth_r <= depth_nxt;
      bump_r  <= bump_nxt;
    end
  end

  // job payload holds from acceptance until the result is loaded
  always_ff @(posedge clk) begin
    if (in_fire) begin
      job_r <= job_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Free stack RAM: push writes at depth, pop reads at depth - 1
  // --------------------------------------------------------------------------
  dsa_pkg::slot_idx_t ram_rdata;

  dsa_stack_ram #(
    .DEPTH (MAX_SLOTS),
    .AW    (AW)
  ) u_stack_ram (
    .clk   (clk),
    .we    (in_fire && push),
    .waddr (depth_r[AW-1:0]),
    .wdata (in_free_index),
    .re    (in_fire && pop),
    .raddr (depth_dec[AW-1:0]),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Address calculation
  // --------------------------------------------------------------------------
  dsa_pkg::slot_idx_t au_idx;
  dsa_pkg::addr_t     au_cpu;
  dsa_pkg::addr_t     au_gpu;

  dsa_addr_unit u_addr_unit (
    .clk            (clk),
    .calc_en        (calc_en),
    .job            (job_r),
    .ram_idx        (ram_rdata),
    .stride         (stride_r),
    .cpu_base       (cpu_base_r),
    .gpu_base       (gpu_base_r),
    .shader_visible (vis_r),
    .slot_idx       (au_idx),
    .cpu_addr       (au_cpu),
    .gpu_addr       (au_gpu)
  );

  // --------------------------------------------------------------------------
  // Output register: hold the result word until out_ready
  // --------------------------------------------------------------------------
  dsa_pkg::status_t   out_status_r;
  dsa_pkg::slot_idx_t out_idx_r;
  dsa_pkg::addr_t     out_cpu_r;
  dsa_pkg::addr_t     out_gpu_r;
  dsa_pkg::free_cnt_t out_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= job_r.status;
      out_idx_r    <= au_idx;
      out_cpu_r    <= au_cpu;
      out_gpu_r    <= au_gpu;
      out_cnt_r    <= job_r.free_count;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_index  = out_idx_r;
  assign out_cpu_address = out_cpu_r;
  assign out_gpu_address = out_gpu_r;
  assign out_free_count  = out_cnt_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // stack depth never passes the stack size
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(MAX_SLOTS))
    else $error("free stack depth above MAX_SLOTS");

  // an accepted word leaves the idle state on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != dsa_pkg::S_IDLE))
    else $error("sequencer idle right after accepting a word");

  // a pop always goes through the RAM read cycle
  a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && pop) |=> (state_r == dsa_pkg::S_POP))
    else $error("pop skipped the free stack read");

  // a loaded result is presented on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

/* sv/dsa_stack_ram.sv */
// ----------------------------------------------------------------------------
// dsa_stack_ram
// Free stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dsa_stack_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  dsa_pkg::slot_idx_t   wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output dsa_pkg::slot_idx_t   rdata
);

  dsa_pkg::slot_idx_t mem [DEPTH];
  dsa_pkg::slot_idx_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/dsa_addr_unit.sv */
// ----------------------------------------------------------------------------
// dsa_addr_unit
// Slot address generation: registered index times stride, then base add.
// ----------------------------------------------------------------------------
module dsa_addr_unit (
  input  logic                         clk,
  input  logic                         calc_en,
  input  dsa_pkg::job_t                job,
  input  dsa_pkg::slot_idx_t           ram_idx,
  input  logic [dsa_pkg::STRD_W-1:0]   stride,
  input  dsa_pkg::addr_t               cpu_base,
  input  dsa_pkg::addr_t               gpu_base,
  input  logic                         shader_visible,
  output dsa_pkg::slot_idx_t           slot_idx,
  output dsa_pkg::addr_t               cpu_addr,
  output dsa_pkg::addr_t               gpu_addr
);

  dsa_pkg::slot_idx_t              idx_sel;
  logic [dsa_pkg::PROD_W-1:0]      prod_r;
  dsa_pkg::slot_idx_t              idx_r;
  logic                            got_r;
  dsa_pkg::addr_t                  off;

  // Zero the index on a free or a failed allocate
  always_comb begin
    idx_sel = '0;
    if (job.got) begin
      idx_sel = job.from_ram ? ram_idx : job.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (calc_en) begin
      prod_r <= dsa_pkg::PROD_W'(idx_sel) * dsa_pkg::PROD_W'(stride);
      idx_r  <= idx_sel;
      got_r  <= job.got;
    end
  end

  assign off      = dsa_pkg::ADDR_W'(prod_r);
  assign slot_idx = idx_r;
  assign cpu_addr = got_r ? cpu_base + off : '0;
  assign gpu_addr = (got_r && shader_visible) ? gpu_base + off : '0;

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the descriptor slot allocator core.
// ----------------------------------------------------------------------------
// Input words (allocate / free) go in over a valid/ready channel. Every
// accepted word is run through a cycle-free predictor of the free stack,
// the bump pointer and the address math. The expected result word is queued
// and compared field by field with each result word the block hands out.
// Directed tests cover the reset values, register extremes and capacity
// edges. Random traffic with several register settings and idle profiles
// follows, including one long receiver hold-off, and a full free stack last.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned MAX_SLOTS   = 1024;
  localparam int          IDLE_SETTLE = 8;     // cycles past the last result
  localparam int          MAX_REPORTS = 100;   // keep the log short

  // One result word as predicted or observed
  typedef struct {
    dsa_pkg::status_t   status;
    dsa_pkg::slot_idx_t slot;
    dsa_pkg::addr_t     cpu;
    dsa_pkg::addr_t     gpu;
    dsa_pkg::free_cnt_t fcnt;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid;
  logic                          in_ready;
  logic                          in_opcode;
  logic [dsa_pkg::IDX_W-1:0]     in_free_index;
  logic                          in_handle_valid;
  logic                          out_valid;
  logic                          out_ready;
  logic [1:0]                    out_status;
  logic [dsa_pkg::IDX_W-1:0]     out_slot_index;
  logic [dsa_pkg::ADDR_W-1:0]    out_cpu_address;
  logic [dsa_pkg::ADDR_W-1:0]    out_gpu_address;
  logic [dsa_pkg::CNT_W-1:0]     out_free_count;
  logic                          cfg_we;
  logic [dsa_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dsa_pkg::ADDR_W-1:0]    cfg_wdata;

  // Predictor copy of the registers
  logic [dsa_pkg::CAP_W-1:0]  heap_cap;
  logic [dsa_pkg::STRD_W-1:0] heap_stride;
  dsa_pkg::addr_t             heap_cpu_base;
  dsa_pkg::addr_t             heap_gpu_base;
  logic                       heap_visible;

  // Predictor copy of the allocator state
  dsa_pkg::slot_idx_t         freed_slots [0:MAX_SLOTS-1];
  logic [dsa_pkg::CAP_W-1:0]  freed_depth;
  logic [dsa_pkg::CAP_W-1:0]  bump_next;

  outcome_t           awaited_outcomes[$];
  dsa_pkg::slot_idx_t live_slots[$];        // handed out and not yet returned

  // Idle profile and receiver hold-off
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int holdoff_req  = 0;
  int hold_left    = 0;

  // Run statistics
  int n_errors     = 0;
  int n_sent       = 0;
  int n_results    = 0;
  int n_cfg_writes = 0;
  int n_in_stalls  = 0;
  int status_seen [4];

  descriptor_slot_allocator_core #(
    .MAX_SLOTS(MAX_SLOTS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_free_index  (in_free_index),
    .in_handle_valid(in_handle_valid),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot_index (out_slot_index),
    .out_cpu_address(out_cpu_address),
    .out_gpu_address(out_gpu_address),
    .out_free_count (out_free_count),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor: one allocate or free, updates the state copy and returns the
  // result word the block must produce for it.
  // --------------------------------------------------------------------------
  function automatic outcome_t compute_slot_outcome(input dsa_pkg::opcode_t op,
                                                    input dsa_pkg::slot_idx_t fidx,
                                                    input logic hv);
    outcome_t                  o;
    logic [dsa_pkg::CAP_W-1:0] cap_eff;
    logic [dsa_pkg::CAP_W-1:0] fresh;
    dsa_pkg::slot_idx_t        idx;
    logic                      got;
    dsa_pkg::addr_t            off;
    o.status = dsa_pkg::ST_OK;
    o.slot   = '0;
    o.cpu    = '0;
    o.gpu    = '0;
    got      = 1'b0;
    idx      = '0;
    // capacity saturates at the stack size
    cap_eff = (heap_cap > dsa_pkg::CAP_W'(MAX_SLOTS)) ? dsa_pkg::CAP_W'(MAX_SLOTS)
                                                      : heap_cap;
    if (op == dsa_pkg::OP_ALLOC) begin
      // most recently freed slot first, then the bump pointer
      if (freed_depth != '0) begin
        freed_depth = freed_depth - dsa_pkg::CAP_W'(1);
        idx = freed_slots[freed_depth];
        got = 1'b1;
      end else if (bump_next < cap_eff) begin
        idx = bump_next[dsa_pkg::IDX_W-1:0];
        bump_next = bump_next + dsa_pkg::CAP_W'(1);
        got = 1'b1;
      end
      if (got) begin
        off = {54'd0, idx} * {48'd0, heap_stride};
        o.slot = idx;
        o.cpu  = heap_cpu_base + off;
        o.gpu  = heap_visible ? heap_gpu_base + off : '0;
      end else begin
        o.status = dsa_pkg::ST_HEAP_FULL;
      end
    end else if (!hv) begin
      o.status = dsa_pkg::ST_BAD_HANDLE;
    end else if (freed_depth >= dsa_pkg::CAP_W'(MAX_SLOTS)) begin
      o.status = dsa_pkg::ST_OVERFLOW;
    end else begin
      // pushed as given: no range or duplicate check
      freed_slots[freed_depth] = fidx;
      freed_depth = freed_depth + dsa_pkg::CAP_W'(1);
    end
    // bump source counts as empty once capacity is at or below it
    fresh = (bump_next < cap_eff) ? cap_eff - bump_next : '0;
    o.fcnt = {1'b0, fresh} + {1'b0, freed_depth};
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one input word, with a random gap in front of it. Valid rises at
  // a falling edge and holds with the payload until accepted; the word is
  // predicted at the accepting edge.
  // --------------------------------------------------------------------------
  task automatic send_word(input dsa_pkg::opcode_t op, input dsa_pkg::slot_idx_t fidx,
                           input logic hv, output outcome_t o);
    int gap;
    gap = ($urandom_range(0, 99) < src_idle_pct) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_free_index   <= fidx;
    in_handle_valid <= hv;
    do @(posedge clk); while (!in_ready);
    o = compute_slot_outcome(op, fidx, hv);
    awaited_outcomes.insert(awaited_outcomes.size(), o);
    if (op == dsa_pkg::OP_ALLOC && o.status == dsa_pkg::ST_OK)
      live_slots.insert(live_slots.size(), o.slot);
    n_sent++;
  endtask

  // Drop valid and wait until every result word has come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // Register write; only called while the block is idle
  task automatic write_reg(input dsa_pkg::cfg_idx_t idx, input dsa_pkg::addr_t data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      dsa_pkg::CFG_CAPACITY:       heap_cap      = data[dsa_pkg::CAP_W-1:0];
      dsa_pkg::CFG_STRIDE_BYTES:   heap_stride   = data[dsa_pkg::STRD_W-1:0];
      dsa_pkg::CFG_CPU_BASE:       heap_cpu_base = data;
      dsa_pkg::CFG_GPU_BASE:       heap_gpu_base = data;
      dsa_pkg::CFG_SHADER_VISIBLE: heap_visible  = data[0];
      default: ;
    endcase
    n_cfg_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random ready, or a long hold-off counted here when requested
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (holdoff_req > 0) begin
      hold_left   = holdoff_req;
      holdoff_req = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_ready) n_in_stalls++;
  end

  // --------------------------------------------------------------------------
  // Result check: compare each accepted result word with the oldest
  // expectation
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input dsa_pkg::addr_t want,
                             input dsa_pkg::addr_t seen);
    if (want !== seen) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%0t mismatch on %s: expected %0h actual %0h", $time, name, want, seen);
    end
  endtask

  always @(posedge clk) begin : result_check
    outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_outcomes.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t unexpected result word: expected none actual status %0h slot %0h",
                   $time, out_status, out_slot_index);
      end else begin
        want = awaited_outcomes.pop_front();
        check_field("status",      dsa_pkg::addr_t'(want.status),
                    dsa_pkg::addr_t'(out_status));
        check_field("slot_index",  dsa_pkg::addr_t'(want.slot),
                    dsa_pkg::addr_t'(out_slot_index));
        check_field("cpu_address", want.cpu, out_cpu_address);
        check_field("gpu_address", want.gpu, out_gpu_address);
        check_field("free_count",  dsa_pkg::addr_t'(want.fcnt),
                    dsa_pkg::addr_t'(out_free_count));
        if (!$isunknown(out_status)) status_seen[out_status]++;
        n_results++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: stride 32, zero bases, GPU address off
  task automatic test_reset_values();
    outcome_t o;
    send_word(dsa_pkg::OP_ALLOC, 10'h3FF, 1'b1, o);
    send_word(dsa_pkg::OP_ALLOC, 10'h000, 1'b0, o);
    // invalid handle leaves the state alone
    send_word(dsa_pkg::OP_FREE, 10'h3FF, 1'b0, o);
  endtask

  // Widest stride and all-ones bases: addresses wrap at 64 bits
  task automatic test_register_extremes();
    outcome_t o;
    wait_idle();
    write_reg(dsa_pkg::CFG_STRIDE_BYTES, 64'hFFFF);
    write_reg(dsa_pkg::CFG_CPU_BASE, '1);
    write_reg(dsa_pkg::CFG_GPU_BASE, '1);
    write_reg(dsa_pkg::CFG_SHADER_VISIBLE, 64'd1);
    send_word(dsa_pkg::OP_ALLOC, 10'h155, 1'b0, o);
    // never-allocated index is pushed as given, then popped: largest offset
    send_word(dsa_pkg::OP_FREE, 10'h3FF, 1'b1, o);
    send_word(dsa_pkg::OP_ALLOC, 10'h2AA, 1'b1, o);
    send_word(dsa_pkg::OP_FREE, 10'h000, 1'b1, o);
    send_word(dsa_pkg::OP_ALLOC, 10'h000, 1'b0, o);
    // duplicate frees are not caught: same slot comes back twice
    send_word(dsa_pkg::OP_FREE, 10'h005, 1'b1, o);
    send_word(dsa_pkg::OP_FREE, 10'h005, 1'b1, o);
    send_word(dsa_pkg::OP_ALLOC, 10'h000, 1'b0, o);
    send_word(dsa_pkg::OP_ALLOC, 10'h000, 1'b0, o);
    wait_idle();
    write_reg(dsa_pkg::CFG_SHADER_VISIBLE, 64'd0);
    send_word(dsa_pkg::OP_ALLOC, 10'h000, 1'b0, o);
  endtask

  // Capacity zero, lowered below the bump pointer, and above the stack size
  task automatic test_capacity_edges();
    outcome_t o;
    wait_idle();
    write_reg(dsa_pkg::CFG_CAPACITY, 64'd0);
    write_reg(dsa_pkg::CFG_STRIDE_BYTES, 64'd0);
    write_reg(dsa_pkg::CFG_CPU_BASE, 64'd0);
    send_word(dsa_pkg::OP_ALLOC, 10'h000, 1'b0, o);
    // freed slots are still served with the bump source exhausted
    send_word(dsa_pkg::OP_FREE, 10'h007, 1'b1, o);
    send_word(dsa_pkg::OP_ALLOC, 10'h000, 1'b0, o);
    send_word(dsa_pkg::OP_ALLOC, 10'h000, 1'b0, o);
    wait_idle();
    write_reg(dsa_pkg::CFG_CAPACITY, 64'h7FF);
    send_word(dsa_pkg::OP_ALLOC, 10'h3FF, 1'b1, o);
    wait_idle();
    write_reg(dsa_pkg::CFG_CAPACITY, 64'd1025);
    write_reg(dsa_pkg::CFG_STRIDE_BYTES, 64'd24);
    send_word(dsa_pkg::OP_ALLOC, 10'h000, 1'b0, o);
    wait_idle();
    write_reg(dsa_pkg::CFG_CAPACITY, 64'(bump_next + dsa_pkg::CAP_W'(1)));
    send_word(dsa_pkg::OP_ALLOC, 10'h000, 1'b0, o);
    send_word(dsa_pkg::OP_ALLOC, 10'h000, 1'b0, o);
  endtask

  // Fill the free stack, push past full, then pop a few back out
  task automatic test_stack_full();
    outcome_t o;
    while (freed_depth < dsa_pkg::CAP_W'(MAX_SLOTS))
      send_word(dsa_pkg::OP_FREE, dsa_pkg::slot_idx_t'($urandom_range(0, 1023)), 1'b1, o);
    send_word(dsa_pkg::OP_FREE, 10'h2A5, 1'b1, o);
    // handle check comes before the full check
    send_word(dsa_pkg::OP_FREE, 10'h15A, 1'b0, o);
    send_word(dsa_pkg::OP_ALLOC, 10'h000, 1'b0, o);
    send_word(dsa_pkg::OP_FREE, 10'h0F0, 1'b1, o);
    send_word(dsa_pkg::OP_FREE, 10'h00F, 1'b1, o);
    repeat (6) send_word(dsa_pkg::OP_ALLOC, 10'h000, 1'b0, o);
    live_slots.delete();
  endtask

  // One random phase: program every register, then mostly well-formed
  // allocate/free traffic with some stray and invalid frees mixed in
  task automatic run_phase(input int src_pct, input int snk_pct,
                           input logic [dsa_pkg::CAP_W-1:0] cap,
                           input logic [dsa_pkg::STRD_W-1:0] stride,
                           input dsa_pkg::addr_t cbase, input dsa_pkg::addr_t gbase,
                           input logic vis, input int n_items, input int hold);
    outcome_t           o;
    dsa_pkg::slot_idx_t fidx;
    int                 r;
    int                 k;
    wait_idle();
    write_reg(dsa_pkg::CFG_CAPACITY, 64'(cap));
    write_reg(dsa_pkg::CFG_STRIDE_BYTES, 64'(stride));
    write_reg(dsa_pkg::CFG_CPU_BASE, cbase);
    write_reg(dsa_pkg::CFG_GPU_BASE, gbase);
    write_reg(dsa_pkg::CFG_SHADER_VISIBLE, 64'(vis));
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    if (hold > 0) holdoff_req = hold;
    repeat (n_items) begin
      r    = $urandom_range(0, 99);
      fidx = dsa_pkg::slot_idx_t'($urandom_range(0, 1023));
      if (r < 48) begin
        // ignored fields carry random bits
        send_word(dsa_pkg::OP_ALLOC, fidx, 1'($urandom_range(0, 1)), o);
      end else if (r < 80 && live_slots.size() != 0) begin
        k    = $urandom_range(0, live_slots.size() - 1);
        fidx = live_slots[k];
        live_slots.delete(k);
        send_word(dsa_pkg::OP_FREE, fidx, 1'b1, o);
      end else if (r < 90) begin
        send_word(dsa_pkg::OP_FREE, fidx, 1'b1, o);
      end else begin
        send_word(dsa_pkg::OP_FREE, fidx, 1'b0, o);
      end
    end
  endtask

  task automatic test_random_traffic();
    dsa_pkg::addr_t rnd_a;
    dsa_pkg::addr_t rnd_b;
    rnd_a = {$urandom, $urandom};
    rnd_b = {$urandom, $urandom};
    run_phase(16, 54, bump_next + dsa_pkg::CAP_W'($urandom_range(8, 40)),
              dsa_pkg::STRD_W'($urandom), rnd_a, rnd_b, 1'b1, 130, 0);
    run_phase(16, 54, 11'h7FF, 16'hFFFF, '1, '1, 1'($urandom_range(0, 1)), 130, 0);
    rnd_a = {$urandom, $urandom};
    run_phase(54, 16, 11'd1, dsa_pkg::STRD_W'($urandom), rnd_a, '0, 1'b0, 130, 0);
    rnd_a = {$urandom, $urandom};
    rnd_b = {$urandom, $urandom};
    run_phase(54, 16, dsa_pkg::CAP_W'($urandom_range(0, 2047)), dsa_pkg::STRD_W'($urandom),
              rnd_a, rnd_b, 1'b1, 130, 0);
    // long receiver hold-off while the sender keeps offering words
    rnd_a = {$urandom, $urandom};
    run_phase(0, 0, bump_next + 11'd64, dsa_pkg::STRD_W'($urandom), rnd_a, '1, 1'b1,
              120, 200);
    run_phase(0, 0, dsa_pkg::CAP_W'(MAX_SLOTS), 16'd0, '0, '0, 1'b1, 120, 0);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    in_valid        = 1'b0;
    in_opcode       = 1'b0;
    in_free_index   = '0;
    in_handle_valid = 1'b0;
    out_ready       = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    // predictor starts at the reset values
    heap_cap      = dsa_pkg::CAP_W'(1024);
    heap_stride   = dsa_pkg::STRD_W'(32);
    heap_cpu_base = '0;
    heap_gpu_base = '0;
    heap_visible  = 1'b0;
    freed_depth   = '0;
    bump_next     = '0;
    src_idle_pct  = 16;
    snk_idle_pct  = 54;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_register_extremes();
    test_capacity_edges();
    test_random_traffic();
    test_stack_full();

    wait_idle();
    repeat (20) @(posedge clk);

    $display("covered %0d input words, %0d result words, %0d register writes, %0d stall cycles",
             n_sent, n_results, n_cfg_writes, n_in_stalls);
    $display("status counts: ok %0d, heap full %0d, bad handle %0d, overflow %0d",
             status_seen[dsa_pkg::ST_OK], status_seen[dsa_pkg::ST_HEAP_FULL],
             status_seen[dsa_pkg::ST_BAD_HANDLE], status_seen[dsa_pkg::ST_OVERFLOW]);
    if (n_errors == 0 && awaited_outcomes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2000000;
    $display("timeout with %0d result words outstanding", awaited_outcomes.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* descriptor_slot_allocator_core.f */
sv/dsa_pkg.sv
sv/dsa_stack_ram.sv
sv/dsa_addr_unit.sv
sv/descriptor_slot_allocator_core.sv
dv/tb_top.sv
